// ===== sv/bed_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bed_pkg
// Shared types, register map and helpers for the bounded edit distance core.
// ----------------------------------------------------------------------------
package bed_pkg;

    // Width of DP values over the full parameter range (lengths up to 256).
    localparam int VAL_W = 9;

    // Largest effective distance limit.
    localparam logic [6:0] LIMIT_CAP = 7'd64;

    // Configuration address width and register indexes.
    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_LIMIT  = 2'd0;
    localparam logic [1:0] REG_LEN_EN = 2'd1;
    localparam logic [1:0] REG_FOLD   = 2'd2;

    // Column token handed from one cell to the next.
    typedef struct packed {
        logic             valid;
        logic [7:0]       chr;
        logic [VAL_W-1:0] left;
        logic [VAL_W-1:0] diag;
    } t_token;

    function automatic logic [7:0] fold_char(input logic [7:0] c, input logic en);
        logic [7:0] r;
        r = c;
        if (en && c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/bed_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bed_in_if
// Input channel: query and name characters, one per beat.
// ----------------------------------------------------------------------------
interface bed_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] char_code;
    logic       last_char;
    logic       empty_string;

    modport source (output valid, action, char_code, last_char, empty_string, input ready);
    modport sink   (input valid, action, char_code, last_char, empty_string, output ready);
endinterface
`default_nettype wire

// ===== sv/bed_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bed_out_if
// Output channel: one distance result per name.
// ----------------------------------------------------------------------------
interface bed_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] distance;
    logic       beyond_limit;
    logic       length_overflow;

    modport source (output valid, distance, beyond_limit, length_overflow, input ready);
    modport sink   (input valid, distance, beyond_limit, length_overflow, output ready);
endinterface
`default_nettype wire

// ===== sv/bed_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bed_cell
// One query row: holds its character, DP value and row minimum, updates on
// each column token and forwards the token to the next row.
// ----------------------------------------------------------------------------
module bed_cell (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_reload,
    input  wire logic [bed_pkg::VAL_W-1:0]   i_row,
    input  wire logic                        i_fold,
    input  wire logic                        i_q_we,
    input  wire logic [7:0]                  i_q_char,
    input  wire bed_pkg::t_token             i_tok,
    output bed_pkg::t_token                  o_tok,
    output logic [bed_pkg::VAL_W-1:0]        o_dp,
    output logic [bed_pkg::VAL_W-1:0]        o_min
);

    logic [7:0]                r_q;
    logic [bed_pkg::VAL_W-1:0] r_dp;
    logic [bed_pkg::VAL_W-1:0] r_min;
    bed_pkg::t_token           r_tok;

    logic                      cost;
    logic [bed_pkg::VAL_W-1:0] up_v;
    logic [bed_pkg::VAL_W-1:0] left_v;
    logic [bed_pkg::VAL_W-1:0] diag_v;
    logic [bed_pkg::VAL_W-1:0] m_v;
    logic [bed_pkg::VAL_W-1:0] v;

    always_comb begin
        cost   = (bed_pkg::fold_char(r_q, i_fold) != i_tok.chr);
        up_v   = r_dp + bed_pkg::VAL_W'(1);
        left_v = i_tok.left + bed_pkg::VAL_W'(1);
        diag_v = i_tok.diag + bed_pkg::VAL_W'(cost);
        m_v    = (up_v < left_v) ? up_v : left_v;
        v      = (m_v < diag_v) ? m_v : diag_v;
    end

    always_ff @(posedge i_clk) begin
        if (i_q_we) begin
            r_q <= i_q_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_reload) begin
            r_dp      <= i_row;
            r_min     <= i_row;
            r_tok.valid <= 1'b0;
        end else if (i_tok.valid) begin
            r_dp        <= v;
            if (v < r_min) begin
                r_min <= v;
            end
            r_tok.valid <= 1'b1;
            r_tok.chr   <= i_tok.chr;
            r_tok.left  <= v;
            r_tok.diag  <= r_dp;
        end else begin
            r_tok.valid <= 1'b0;
        end
    end

    assign o_tok = r_tok;
    assign o_dp  = r_dp;
    assign o_min = r_min;

endmodule
`default_nettype wire

// ===== sv/bounded_edit_distance_core.sv =====
// Result: registered once the drain count, loaded with the query length, reaches zero.
// Throughput: one character per cycle while running; a name end blocks input until
// its result is captured, which waits while an earlier result holds the output register.
// Each name column ripples through the cell row one cell per cycle.
// Reset: limit 2, bound on, case folding off, empty open query, no result pending.
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_edit_distance_core
// Bounded Levenshtein distance of streamed names against a stored query,
// computed by a systolic row of query cells.
// ----------------------------------------------------------------------------
module bounded_edit_distance_core #(
    parameter int MAX_QUERY_LEN = 32,
    parameter int MAX_NAME_LEN  = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    bed_in_if.sink                           i_in,
    bed_out_if.source                        o_out,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bed_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    localparam int QLW = $clog2(MAX_QUERY_LEN + 1);
    localparam int NLW = $clog2(MAX_NAME_LEN + 1);
    localparam int VW  = bed_pkg::VAL_W;

    localparam logic ST_RUN   = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    // Configuration
    logic [6:0] r_limit;
    logic       r_len_en;
    logic       r_fold;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= 7'd2;
            r_len_en <= 1'b1;
            r_fold   <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                bed_pkg::REG_LIMIT:  r_limit  <= pwdata[6:0];
                bed_pkg::REG_LEN_EN: r_len_en <= pwdata[0];
                bed_pkg::REG_FOLD:   r_fold   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            bed_pkg::REG_LIMIT:  prdata = {25'd0, r_limit};
            bed_pkg::REG_LEN_EN: prdata = {31'd0, r_len_en};
            bed_pkg::REG_FOLD:   prdata = {31'd0, r_fold};
            default:             prdata = 32'd0;
        endcase
    end

    // Control state
    logic             r_state,   n_state;
    logic [QLW-1:0]   r_qlen,    n_qlen;
    logic             r_qovf,    n_qovf;
    logic             r_qclosed, n_qclosed;
    logic [NLW-1:0]   r_nlen,    n_nlen;
    logic             r_novf,    n_novf;
    logic [QLW-1:0]   r_cnt,     n_cnt;
    bed_pkg::t_token  r_head,    n_head;
    logic             r_ovalid,  n_ovalid;
    logic [6:0]       r_dist,    n_dist;
    logic             r_beyond,  n_beyond;
    logic             r_lovf,    n_lovf;

    logic             in_beat;
    logic             ends;
    logic             reload;
    logic             q_wr;
    logic [QLW-1:0]   q_base;
    logic             capture;

    // Cell row
    bed_pkg::t_token  tok    [MAX_QUERY_LEN];
    logic [VW-1:0]    cell_dp  [MAX_QUERY_LEN];
    logic [VW-1:0]    cell_min [MAX_QUERY_LEN];

    // Result terms
    logic [6:0]       lim;
    logic [VW-1:0]    n_v;
    logic [VW-1:0]    m_v;
    logic [VW-1:0]    diff;
    logic [VW-1:0]    sel_dp;
    logic             row_over;
    logic [VW-1:0]    res_d;
    logic             res_beyond;

    assign i_in.ready = (r_state == ST_RUN);
    assign in_beat    = i_in.valid && i_in.ready;
    assign ends       = i_in.last_char || i_in.empty_string;
    assign capture    = (r_state == ST_DRAIN) && (r_cnt == '0) && (!r_ovalid || o_out.ready);

    always_comb begin
        lim      = (r_limit > bed_pkg::LIMIT_CAP) ? bed_pkg::LIMIT_CAP : r_limit;
        n_v      = VW'(r_qlen);
        m_v      = VW'(r_nlen);
        diff     = (n_v > m_v) ? (n_v - m_v) : (m_v - n_v);
        sel_dp   = '0;
        row_over = 1'b0;
        for (int i = 0; i < MAX_QUERY_LEN; i++) begin
            if (r_qlen == QLW'(i + 1)) begin
                sel_dp = cell_dp[i];
            end
            if ((QLW'(i) < r_qlen) && (cell_min[i] > VW'(lim))) begin
                row_over = 1'b1;
            end
        end
        res_beyond = 1'b0;
        if (r_qlen == '0) begin
            res_d = m_v;
        end else if (r_nlen == '0) begin
            res_d = n_v;
        end else begin
            res_d = sel_dp;
            if (r_len_en && ((diff > VW'(lim)) || row_over)) begin
                res_d      = VW'(lim) + VW'(1);
                res_beyond = 1'b1;
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_qlen    = r_qlen;
        n_qovf    = r_qovf;
        n_qclosed = r_qclosed;
        n_nlen    = r_nlen;
        n_novf    = r_novf;
        n_cnt     = r_cnt;
        n_head    = r_head;
        n_head.valid = 1'b0;
        n_ovalid  = r_ovalid;
        n_dist    = r_dist;
        n_beyond  = r_beyond;
        n_lovf    = r_lovf;
        reload    = 1'b0;
        q_wr      = 1'b0;
        q_base    = r_qlen;

        if (o_out.valid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        if (in_beat) begin
            if (!i_in.action) begin
                reload = 1'b1;
                n_nlen = '0;
                n_novf = 1'b0;
                if (r_qclosed) begin
                    q_base    = '0;
                    n_qlen    = '0;
                    n_qovf    = 1'b0;
                    n_qclosed = 1'b0;
                end
                if (!i_in.empty_string) begin
                    if (q_base < QLW'(MAX_QUERY_LEN)) begin
                        q_wr   = 1'b1;
                        n_qlen = q_base + QLW'(1);
                    end else begin
                        n_qovf = 1'b1;
                    end
                end
                if (ends) begin
                    n_qclosed = 1'b1;
                end
            end else begin
                n_qclosed = 1'b1;
                if (!i_in.empty_string) begin
                    if (r_nlen < NLW'(MAX_NAME_LEN)) begin
                        n_nlen       = r_nlen + NLW'(1);
                        n_head.valid = 1'b1;
                        n_head.chr   = bed_pkg::fold_char(i_in.char_code, r_fold);
                        n_head.left  = VW'(r_nlen) + VW'(1);
                        n_head.diag  = VW'(r_nlen);
                    end else begin
                        n_novf = 1'b1;
                    end
                end
                if (ends) begin
                    n_state = ST_DRAIN;
                    n_cnt   = r_qlen;
                end
            end
        end

        if (capture) begin
            n_ovalid = 1'b1;
            n_dist   = res_d[6:0];
            n_beyond = res_beyond;
            n_lovf   = r_qovf || r_novf;
            reload   = 1'b1;
            n_nlen   = '0;
            n_novf   = 1'b0;
            n_state  = ST_RUN;
        end else if ((r_state == ST_DRAIN) && (r_cnt != '0)) begin
            n_cnt = r_cnt - QLW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_RUN;
            r_qlen       <= '0;
            r_qovf       <= 1'b0;
            r_qclosed    <= 1'b0;
            r_nlen       <= '0;
            r_novf       <= 1'b0;
            r_cnt        <= '0;
            r_head.valid <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_qlen    <= n_qlen;
            r_qovf    <= n_qovf;
            r_qclosed <= n_qclosed;
            r_nlen    <= n_nlen;
            r_novf    <= n_novf;
            r_cnt     <= n_cnt;
            r_head    <= n_head;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dist   <= n_dist;
        r_beyond <= n_beyond;
        r_lovf   <= n_lovf;
    end

    assign o_out.valid           = r_ovalid;
    assign o_out.distance        = r_dist;
    assign o_out.beyond_limit    = r_beyond;
    assign o_out.length_overflow = r_lovf;

    assign tok[0] = r_head;

    for (genvar g = 0; g < MAX_QUERY_LEN; g++) begin : g_cell
        if (g == MAX_QUERY_LEN - 1) begin : g_last
            bed_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_reload (reload),
                .i_row    (VW'(g + 1)),
                .i_fold   (r_fold),
                .i_q_we   (q_wr && (q_base == QLW'(g))),
                .i_q_char (i_in.char_code),
                .i_tok    (tok[g]),
                .o_tok    (),
                .o_dp     (cell_dp[g]),
                .o_min    (cell_min[g])
            );
        end else begin : g_mid
            bed_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_reload (reload),
                .i_row    (VW'(g + 1)),
                .i_fold   (r_fold),
                .i_q_we   (q_wr && (q_base == QLW'(g))),
                .i_q_char (i_in.char_code),
                .i_tok    (tok[g]),
                .o_tok    (tok[g+1]),
                .o_dp     (cell_dp[g]),
                .o_min    (cell_min[g])
            );
        end
    end

endmodule
`default_nettype wire

// ===== dv/bed_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bed_tb_pkg
// Beat codes shared by the stimulus and the distance checker.
// ----------------------------------------------------------------------------
package bed_tb_pkg;

    typedef enum logic {
        ACT_QUERY = 1'b0,
        ACT_NAME  = 1'b1
    } t_action;

endpackage

// ===== dv/bed_distance_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bed_distance_check
// Watches the character, result and register ports of the edit distance core,
// keeps its own DP column per query row, and compares every result beat
// against the oldest predicted distance.
// ----------------------------------------------------------------------------
module bed_distance_check (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    bed_in_if                               i_chars,
    bed_out_if                              i_dists,
    input  wire logic                       i_psel,
    input  wire logic                       i_penable,
    input  wire logic                       i_pwrite,
    input  wire logic                       i_pready,
    input  wire logic [bed_pkg::ADDR_W-1:0] i_paddr,
    input  wire logic [31:0]                i_pwdata,
    output int                              o_fail_count,
    output int                              o_pending
);
    import bed_pkg::*;
    import bed_tb_pkg::*;

    localparam int QRY_CAP  = 32;
    localparam int NAME_CAP = 64;

    typedef struct packed {
        logic [6:0] distance;
        logic       beyond_limit;
        logic       length_overflow;
    } t_dist_result;

    logic [6:0]   cfg_limit;
    logic         cfg_bound_on;
    logic         cfg_fold;

    logic [7:0]   qry_text [QRY_CAP];
    logic [5:0]   qry_len;
    logic         qry_ovf;
    logic         qry_done;
    logic [6:0]   col [QRY_CAP+1];
    logic [6:0]   row_floor [QRY_CAP];
    logic [6:0]   name_len;
    logic         name_ovf;

    t_dist_result pending_distances [$];

    function automatic logic [7:0] cmp_key(input logic [7:0] c);
        if (cfg_fold && c >= 8'h41 && c <= 8'h5A) begin
            return c | 8'h20;
        end
        return c;
    endfunction

    function automatic void restart_name();
        for (int i = 0; i <= QRY_CAP; i++) begin
            col[i] = 7'(i);
        end
        for (int i = 0; i < QRY_CAP; i++) begin
            row_floor[i] = 7'(i + 1);
        end
        name_len = '0;
        name_ovf = 1'b0;
    endfunction

    function automatic void add_name_char(input logic [7:0] ch);
        logic [7:0] key;
        logic [7:0] diag;
        logic [7:0] up;
        logic [7:0] best;
        logic [7:0] sub;
        key  = cmp_key(ch);
        diag = {1'b0, col[0]};
        col[0] = name_len;
        for (int i = 1; i <= qry_len; i++) begin
            up   = {1'b0, col[i]};
            sub  = diag + ((cmp_key(qry_text[i-1]) == key) ? 8'd0 : 8'd1);
            best = up + 8'd1;
            if ({1'b0, col[i-1]} + 8'd1 < best) begin
                best = {1'b0, col[i-1]} + 8'd1;
            end
            if (sub < best) begin
                best = sub;
            end
            col[i] = best[6:0];
            if (best[6:0] < row_floor[i-1]) begin
                row_floor[i-1] = best[6:0];
            end
            diag = up;
        end
    endfunction

    function automatic t_dist_result score_name();
        t_dist_result r;
        logic [6:0]   lim;
        logic [6:0]   gap;
        r.beyond_limit    = 1'b0;
        r.length_overflow = qry_ovf | name_ovf;
        lim = (cfg_limit > LIMIT_CAP) ? LIMIT_CAP : cfg_limit;
        if (qry_len == 0) begin
            r.distance = name_len;
        end else if (name_len == 0) begin
            r.distance = {1'b0, qry_len};
        end else begin
            r.distance = col[qry_len];
            if (cfg_bound_on) begin
                gap = ({1'b0, qry_len} > name_len) ? {1'b0, qry_len} - name_len
                                                   : name_len - {1'b0, qry_len};
                if (gap > lim) begin
                    r.beyond_limit = 1'b1;
                end
                for (int i = 0; i < qry_len; i++) begin
                    if (row_floor[i] > lim) begin
                        r.beyond_limit = 1'b1;
                    end
                end
                if (r.beyond_limit) begin
                    r.distance = lim + 7'd1;
                end
            end
        end
        return r;
    endfunction

    function automatic void take_char(input logic act, input logic [7:0] ch,
                                      input logic last, input logic empty);
        logic ends;
        ends = last | empty;
        if (act == ACT_QUERY) begin
            restart_name();
            if (qry_done) begin
                qry_len  = '0;
                qry_ovf  = 1'b0;
                qry_done = 1'b0;
            end
            if (!empty) begin
                if (qry_len < QRY_CAP) begin
                    qry_text[qry_len] = ch;
                    qry_len = qry_len + 6'd1;
                end else begin
                    qry_ovf = 1'b1;
                end
            end
            if (ends) begin
                qry_done = 1'b1;
            end
        end else begin
            qry_done = 1'b1;
            if (!empty) begin
                if (name_len < NAME_CAP) begin
                    name_len = name_len + 7'd1;
                    add_name_char(ch);
                end else begin
                    name_ovf = 1'b1;
                end
            end
            if (ends) begin
                pending_distances = {pending_distances, score_name()};
                restart_name();
            end
        end
    endfunction

    function automatic void clear_model();
        cfg_limit    = 7'd2;
        cfg_bound_on = 1'b1;
        cfg_fold     = 1'b0;
        for (int i = 0; i < QRY_CAP; i++) begin
            qry_text[i] = '0;
        end
        qry_len  = '0;
        qry_ovf  = 1'b0;
        qry_done = 1'b0;
        restart_name();
        pending_distances.delete();
    endfunction

    always @(posedge i_clk) begin
        t_dist_result want;
        if (!i_rst_n) begin
            o_fail_count = 0;
            clear_model();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[ADDR_W-1:2])
                    REG_LIMIT:  cfg_limit    = i_pwdata[6:0];
                    REG_LEN_EN: cfg_bound_on = i_pwdata[0];
                    REG_FOLD:   cfg_fold     = i_pwdata[0];
                    default: ;
                endcase
            end
            if (i_dists.valid && i_dists.ready) begin
                if (pending_distances.size() == 0) begin
                    $error("unexpected result beat: distance %0d beyond_limit %0b",
                           i_dists.distance, i_dists.beyond_limit);
                    o_fail_count++;
                end else begin
                    want = pending_distances.pop_front();
                    if (i_dists.distance !== want.distance) begin
                        $error("distance: expected %0d, got %0d",
                               want.distance, i_dists.distance);
                        o_fail_count++;
                    end
                    if (i_dists.beyond_limit !== want.beyond_limit) begin
                        $error("beyond_limit: expected %0b, got %0b",
                               want.beyond_limit, i_dists.beyond_limit);
                        o_fail_count++;
                    end
                    if (i_dists.length_overflow !== want.length_overflow) begin
                        $error("length_overflow: expected %0b, got %0b",
                               want.length_overflow, i_dists.length_overflow);
                        o_fail_count++;
                    end
                end
            end
            if (i_chars.valid && i_chars.ready) begin
                take_char(i_chars.action, i_chars.char_code, i_chars.last_char,
                          i_chars.empty_string);
            end
        end
        o_pending = pending_distances.size();
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams queries and candidate names into the edit distance core in bursts,
// stalls the result port, reprograms the limit, length bound and case folding
// between phases, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
    import bed_pkg::*;
    import bed_tb_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 40;
    localparam int PHASES       = 8;
    localparam int RANDOM_ITEMS = 1450;

    typedef enum {
        SINK_OPEN,
        SINK_CHOPPY,
        SINK_HOLD,
        SINK_BRIEF
    } t_sink_mode;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    int                fail_count;
    int                pending_results;
    int                burst_left;
    int                items_sent;
    int                idle_cycles;
    int                sink_left = 0;
    t_sink_mode        sink_mode = SINK_OPEN;
    logic [7:0]        qry_copy [$];

    bed_in_if  char_bus ();
    bed_out_if dist_bus ();

    bounded_edit_distance_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (char_bus),
        .o_out   (dist_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    bed_distance_check u_distance_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_chars      (char_bus),
        .i_dists      (dist_bus),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (sink_left == 0) begin
            case ($urandom_range(0, 3))
                0: begin
                    sink_mode = SINK_OPEN;
                    sink_left = $urandom_range(20, 150);
                end
                1: begin
                    sink_mode = SINK_CHOPPY;
                    sink_left = $urandom_range(5, 40);
                end
                2: begin
                    sink_mode = SINK_HOLD;
                    sink_left = $urandom_range(1, 20);
                end
                default: begin
                    sink_mode = SINK_BRIEF;
                    sink_left = $urandom_range(1, 8);
                end
            endcase
        end
        sink_left = sink_left - 1;
        case (sink_mode)
            SINK_HOLD:   dist_bus.ready <= 1'b0;
            SINK_CHOPPY: dist_bus.ready <= 1'($urandom_range(0, 1));
            default:     dist_bus.ready <= 1'b1;
        endcase
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (char_bus.valid && char_bus.ready)
                || (dist_bus.valid && dist_bus.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("bounded_edit_distance_core verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send(input t_action act, input logic [7:0] ch, input logic last,
                        input logic empty);
        if (burst_left == 0) begin
            char_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 24);
        end
        char_bus.valid        <= 1'b1;
        char_bus.action       <= act;
        char_bus.char_code    <= ch;
        char_bus.last_char    <= last;
        char_bus.empty_string <= empty;
        @(posedge i_clk);
        while (!char_bus.ready) @(posedge i_clk);
        burst_left = burst_left - 1;
        items_sent++;
    endtask

    task automatic drain_results();
        char_bus.valid <= 1'b0;
        burst_left = 0;
        @(negedge i_clk);
        while (pending_results != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic settle();
        drain_results();
        repeat (HOLD_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [6:0] limit, input logic bound_on,
                                  input logic fold);
        apb_write(REG_LIMIT, {25'd0, limit});
        apb_write(REG_LEN_EN, {31'd0, bound_on});
        apb_write(REG_FOLD, {31'd0, fold});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [7:0] pick_char();
        logic [7:0] c;
        if ($urandom_range(0, 9) < 3) begin
            return 8'($urandom_range(0, 255));
        end
        c = 8'h61 + 8'($urandom_range(0, 3));
        if ($urandom_range(0, 1) == 1) begin
            c = c - 8'h20;
        end
        return c;
    endfunction

    task automatic send_query();
        int len;
        int roll;
        int end_style;
        roll = $urandom_range(0, 99);
        len  = (roll < 10) ? 0 : (roll < 15) ? $urandom_range(33, 40) : $urandom_range(1, 8);
        end_style = $urandom_range(0, 9);
        qry_copy.delete();
        if (len == 0) begin
            send(ACT_QUERY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        end else begin
            for (int i = 0; i < len; i++) begin
                qry_copy = {qry_copy, pick_char()};
                send(ACT_QUERY, qry_copy[i], (i == len - 1) && end_style > 1, 1'b0);
            end
            if (end_style == 1) begin
                send(ACT_QUERY, 8'($urandom_range(0, 255)), 1'b0, 1'b1);
            end
        end
    endtask

    task automatic send_name();
        logic [7:0] nm [$];
        int         roll;
        int         len;
        logic       open_end;
        roll     = $urandom_range(0, 99);
        open_end = ($urandom_range(0, 99) < 12);
        if (roll < 10) begin
            send(ACT_NAME, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
            return;
        end
        if (roll < 15) begin
            len = $urandom_range(60, 72);
            for (int i = 0; i < len; i++) begin
                nm = {nm, pick_char()};
            end
        end else if (roll < 65) begin
            foreach (qry_copy[i]) begin
                case ($urandom_range(0, 9))
                    0: ;
                    1: nm = {nm, pick_char()};
                    2: begin
                        nm = {nm, pick_char()};
                        nm = {nm, qry_copy[i]};
                    end
                    3: nm = {nm, qry_copy[i] ^ 8'h20};
                    default: nm = {nm, qry_copy[i]};
                endcase
            end
            if (nm.size() == 0) begin
                nm = {nm, pick_char()};
            end
        end else begin
            len = $urandom_range(1, 10);
            for (int i = 0; i < len; i++) begin
                nm = {nm, pick_char()};
            end
        end
        foreach (nm[i]) begin
            send(ACT_NAME, nm[i], (i == nm.size() - 1) && !open_end, 1'b0);
        end
    endtask

    task automatic run_random(input int count);
        int start;
        int roll;
        start = items_sent;
        while (items_sent - start < count) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                repeat ($urandom_range(1, 4)) begin
                    send(t_action'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
            end else if (roll < 11) begin
                drain_results();
            end else begin
                send_query();
                repeat ($urandom_range(1, 5)) send_name();
            end
        end
    endtask

    initial begin
        i_rst_n               <= 1'b0;
        char_bus.valid        <= 1'b0;
        char_bus.action       <= ACT_QUERY;
        char_bus.char_code    <= '0;
        char_bus.last_char    <= 1'b0;
        char_bus.empty_string <= 1'b0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        burst_left = 0;
        items_sent = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(ACT_NAME, 8'h7A, 1'b1, 1'b0);
        send(ACT_QUERY, 8'hFF, 1'b0, 1'b1);
        send(ACT_NAME, 8'h61, 1'b0, 1'b0);
        send(ACT_NAME, 8'h62, 1'b1, 1'b0);
        send(ACT_QUERY, 8'h00, 1'b0, 1'b0);
        send(ACT_QUERY, 8'hFF, 1'b1, 1'b0);
        send(ACT_NAME, 8'h55, 1'b0, 1'b1);
        send(ACT_NAME, 8'h00, 1'b0, 1'b0);
        send(ACT_NAME, 8'hFF, 1'b1, 1'b0);
        send(ACT_NAME, 8'h41, 1'b0, 1'b0);
        send(ACT_NAME, 8'h42, 1'b0, 1'b0);
        send(ACT_NAME, 8'h43, 1'b0, 1'b0);
        send(ACT_NAME, 8'h44, 1'b0, 1'b0);
        send(ACT_NAME, 8'h45, 1'b1, 1'b0);
        send(ACT_QUERY, 8'h61, 1'b0, 1'b0);
        send(ACT_QUERY, 8'h62, 1'b0, 1'b0);
        send(ACT_NAME, 8'h41, 1'b0, 1'b0);
        send(ACT_NAME, 8'h42, 1'b1, 1'b0);
        send(ACT_NAME, 8'h78, 1'b0, 1'b0);
        send(ACT_QUERY, 8'h63, 1'b1, 1'b0);
        send(ACT_NAME, 8'h63, 1'b1, 1'b1);
        send(ACT_NAME, 8'h63, 1'b1, 1'b0);

        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            case (phase)
                0: apply_settings(7'd0, 1'b1, 1'b0);
                1: apply_settings(7'd64, 1'b1, 1'b1);
                2: apply_settings(7'd1, 1'b0, 1'b0);
                3: apply_settings(7'd100, 1'b1, 1'b0);
                4: apply_settings(7'd3, 1'b1, 1'b1);
                5: apply_settings(7'd127, 1'b0, 1'b1);
                6: apply_settings(7'($urandom_range(0, 64)), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)));
                default: apply_settings(7'd2, 1'b1, 1'b0);
            endcase
            run_random(RANDOM_ITEMS / PHASES);
        end

        settle();
        if (fail_count == 0 && pending_results == 0) begin
            $display("bounded_edit_distance_core verification clean");
        end else begin
            $display("bounded_edit_distance_core verification failed");
        end
        $finish;
    end

endmodule
